// ===== rtl/bphi_pkg.sv =====
package bphi_pkg;

    localparam int SIDE_W     = 48;
    localparam int PIT_BYTE_W = 8;
    localparam int PIT_BITS   = 5;
    localparam int MAX_PITS   = 6;
    localparam int KEY_W      = PIT_BITS * MAX_PITS;
    localparam int HASH_W     = 32;
    localparam int IDX_BITS_W = 6;
    localparam int MIX_LINES  = 9;

    localparam logic [IDX_BITS_W-1:0] IDX_BITS_RESET = 6'd20;

    localparam logic [HASH_W-1:0] GOLDEN_RATIO = 32'h9e37_79b9;
    localparam logic [HASH_W-1:0] THIRD_WORD   = 32'hfca0_9587;

    // which word a mix line updates
    localparam int WORD_A = 0;
    localparam int WORD_B = 1;
    localparam int WORD_C = 2;

    // shift distance of each mix line, in order
    localparam int MIX_SHIFT [MIX_LINES] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};

    typedef struct packed {
        logic              overflow;
        logic [KEY_W-1:0]  mover_key;
        logic [KEY_W-1:0]  other_key;
        logic [HASH_W-1:0] mask;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] c;
    } bphi_item_t;

    // low-bit mask for the slot index; widths of 32 and up keep every bit
    function automatic logic [HASH_W-1:0] index_mask(input logic [IDX_BITS_W-1:0] bits);
        logic [HASH_W:0] m;
        m = '0;
        if (bits >= IDX_BITS_W'(HASH_W))
        begin
            m = '1;
        end
        else
        begin
            m = ((HASH_W+1)'(1) << bits) - (HASH_W+1)'(1);
        end
        return m[HASH_W-1:0];
    endfunction

endpackage

// ===== rtl/bphi_pack_stage.sv =====
module bphi_pack_stage
    import bphi_pkg::*;
#(
    parameter int PIT_COUNT = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  first_mover_flag,
    input  logic [SIDE_W-1:0]     first_side_pits,
    input  logic [SIDE_W-1:0]     second_side_pits,
    input  logic [IDX_BITS_W-1:0] table_index_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bphi_item_t            out_item
);

    logic             valid_reg;
    bphi_item_t       item_reg;
    bphi_item_t       item_next;
    logic [KEY_W-1:0] key1;
    logic [KEY_W-1:0] key2;
    logic             bad1;
    logic             bad2;

    // pit i sits in byte i; only the low five bits pack, the upper three flag overflow
    always_comb
    begin
        key1 = '0;
        key2 = '0;
        bad1 = 1'b0;
        bad2 = 1'b0;
        for (int i = 0; i < PIT_COUNT; i++)
        begin
            key1[i*PIT_BITS +: PIT_BITS] = first_side_pits[i*PIT_BYTE_W +: PIT_BITS];
            key2[i*PIT_BITS +: PIT_BITS] = second_side_pits[i*PIT_BYTE_W +: PIT_BITS];
            bad1 = bad1 | (|first_side_pits[i*PIT_BYTE_W + PIT_BITS +: PIT_BYTE_W - PIT_BITS]);
            bad2 = bad2 | (|second_side_pits[i*PIT_BYTE_W + PIT_BITS +: PIT_BYTE_W - PIT_BITS]);
        end
    end

    always_comb
    begin
        item_next.overflow = bad1 | bad2;
        if (bad1 | bad2)
        begin
            item_next.mover_key = '0;
            item_next.other_key = '0;
            item_next.mask      = '0;
        end
        else if (first_mover_flag)
        begin
            item_next.mover_key = key1;
            item_next.other_key = key2;
            item_next.mask      = index_mask(table_index_bits);
        end
        else
        begin
            item_next.mover_key = key2;
            item_next.other_key = key1;
            item_next.mask      = index_mask(table_index_bits);
        end
        item_next.a = HASH_W'(item_next.mover_key) + GOLDEN_RATIO;
        item_next.b = HASH_W'(item_next.other_key) + GOLDEN_RATIO;
        item_next.c = THIRD_WORD;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/bphi_mix_stage.sv =====
module bphi_mix_stage
    import bphi_pkg::*;
#(
    parameter int LINE = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bphi_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output bphi_item_t out_item
);

    localparam int WORD = LINE % 3;
    localparam int SH   = MIX_SHIFT[LINE];

    logic       valid_reg;
    bphi_item_t item_reg;
    bphi_item_t item_next;

    // one line of the mix: one word takes two subtracts and a shifted xor
    always_comb
    begin
        item_next = in_item;
        case (WORD)
            WORD_A:
            begin
                item_next.a = (in_item.a - in_item.b - in_item.c) ^ (in_item.c >> SH);
            end
            WORD_B:
            begin
                item_next.b = (in_item.b - in_item.c - in_item.a) ^ (in_item.a << SH);
            end
            WORD_C:
            begin
                item_next.c = (in_item.c - in_item.a - in_item.b) ^ (in_item.b >> SH);
            end
            default:
            begin
                item_next = in_item;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/board_position_hash_index_core.sv =====
// channel    | dir | handshake                     | payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready | tdata: first_side_pits, second_side_pits
//            |     |                               | tuser: first_mover_flag
// m_axis     | out | m_axis_tvalid / m_axis_tready | tdata: mover_key, other_key, slot_index
//            |     |                               | tuser: pit_overflow
// cfg        | in  | cfg_wr_en (no wait)           | cfg_wr_data: table_index_bits
//
// one transaction per cycle sustained while m_axis_tready stays high; a register stage for pit packing
// and key ordering and one for each of the nine mix lines (one subtract pair each)
// reset clears every stage valid bit and loads table_index_bits with 20
// each stage holds its transaction while the stage after it is full and stalled;
// a bubble anywhere is filled at once, so a stall at m_axis drains into the pipe
// before s_axis_tready drops
module board_position_hash_index_core
    import bphi_pkg::*;
#(
    parameter int PIT_COUNT = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [95:0]           s_axis_tdata,  // first_side_pits, second_side_pits
    input  logic                  s_axis_tuser,  // first_mover_flag
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [95:0]           m_axis_tdata,  // mover_key, other_key, slot_index, zero pad
    output logic                  m_axis_tuser,  // pit_overflow
    input  logic                  cfg_wr_en,
    input  logic [IDX_BITS_W-1:0] cfg_wr_data    // table_index_bits
);

    localparam int STAGES = MIX_LINES + 1;

    logic [IDX_BITS_W-1:0] table_index_bits_reg;

    // stage k output; stage 0 packs, stages 1..9 run the mix lines
    logic       stage_valid [STAGES];
    logic       stage_ready [STAGES];
    bphi_item_t stage_item  [STAGES];
    bphi_item_t last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_index_bits_reg <= IDX_BITS_RESET;
        end
        else if (cfg_wr_en)
        begin
            table_index_bits_reg <= cfg_wr_data;
        end
    end

    bphi_pack_stage #(
        .PIT_COUNT (PIT_COUNT)
    ) u_pack (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .first_mover_flag (s_axis_tuser),
        .first_side_pits  (s_axis_tdata[SIDE_W-1:0]),
        .second_side_pits (s_axis_tdata[2*SIDE_W-1:SIDE_W]),
        .table_index_bits (table_index_bits_reg),
        .out_valid        (stage_valid[0]),
        .out_ready        (stage_ready[0]),
        .out_item         (stage_item[0])
    );

    for (genvar k = 1; k < STAGES; k++)
    begin : g_mix
        bphi_mix_stage #(
            .LINE (k - 1)
        ) u_mix (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k-1]),
            .in_ready  (stage_ready[k-1]),
            .in_item   (stage_item[k-1]),
            .out_valid (stage_valid[k]),
            .out_ready (stage_ready[k]),
            .out_item  (stage_item[k])
        );
    end

    assign last_item              = stage_item[STAGES-1];
    assign stage_ready[STAGES-1]  = m_axis_tready;
    assign m_axis_tvalid          = stage_valid[STAGES-1];
    assign m_axis_tuser           = last_item.overflow;

    // mask is already zero on overflow, so the slot index follows
    assign m_axis_tdata = {4'b0000,
                           last_item.c & last_item.mask,
                           last_item.other_key,
                           last_item.mover_key};

    // overflow result carries all-zero keys and index
    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("overflow result with nonzero payload");

    // an empty output stage means nothing upstream can be blocked
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // pits beyond PIT_COUNT never reach the keys
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((last_item.mover_key >> (PIT_BITS * PIT_COUNT)) == '0 &&
                           (last_item.other_key >> (PIT_BITS * PIT_COUNT)) == '0))
        else $error("key holds bits above the configured pits");

endmodule
